// ===== src/gsp_pkg.sv =====
package gsp_pkg;

  localparam int POOL_SIZE = 256;
  localparam int ID_W      = $clog2(POOL_SIZE);
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);
  localparam int GEN_W     = 16;
  localparam int WORD_W    = 64;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [GEN_W-1:0]  gen_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_A1,
    S_A2,
    S_R1,
    S_R2
  } state_t;

  // Free stack request.
  typedef struct packed {
    logic pop;
    logic push;
    id_t  push_id;
  } fs_req_t;

  // Handle table request: generation, live bit and slot-of-id accesses.
  typedef struct packed {
    logic rd;
    id_t  rd_id;
    logic gen_we;
    id_t  gen_id;
    gen_t gen_wdata;
    logic live_set;
    logic live_clr;
    id_t  live_id;
    logic slot_we;
    id_t  slot_wid;
    id_t  slot_wdata;
  } ht_req_t;

  // Dense store request: payload words and slot owner.
  typedef struct packed {
    logic  rd;
    id_t   rd_slot;
    logic  we;
    id_t   wr_slot;
    word_t wx;
    word_t wy;
    id_t   wowner;
  } ds_req_t;

endpackage

// ===== src/gsp_free_stack.sv =====
module gsp_free_stack
  import gsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  fs_req_t req,
  input  cnt_t    free_top,
  output id_t     pop_id
);

  id_t  mem [POOL_SIZE];
  id_t  rd_r;
  id_t  rst_idx_r;
  logic rst_sel_r;
  cnt_t lowmark_r;
  cnt_t lowmark_nxt;
  cnt_t idx;

  // Entries below the low-water mark of the stack pointer were never pushed
  // to, so a pop from one returns its own index, as if set at reset.
  assign idx = free_top - 1'b1;

  always_comb begin
    lowmark_nxt = lowmark_r;
    if (req.pop && (idx < lowmark_r)) begin
      lowmark_nxt = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowmark_r <= CNT_W'(POOL_SIZE);
    end else begin
      lowmark_r <= lowmark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[free_top[ID_W-1:0]] <= req.push_id;
    end
    if (req.pop) begin
      rd_r      <= mem[idx[ID_W-1:0]];
      rst_idx_r <= idx[ID_W-1:0];
      rst_sel_r <= (idx < lowmark_r);
    end
  end

  assign pop_id = rst_sel_r ? rst_idx_r : rd_r;

endmodule

// ===== src/gsp_handle_tab.sv =====
module gsp_handle_tab
  import gsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  ht_req_t req,
  output gen_t    gen_q,
  output logic    live_q,
  output id_t     slot_q
);

  gen_t gen_mem  [POOL_SIZE];
  id_t  slot_mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] gen_vld_r;
  logic [POOL_SIZE-1:0] live_r;
  gen_t gen_rd_r;
  logic gen_vld_rd_r;
  logic live_rd_r;
  id_t  slot_rd_r;

  // Per-id flags: a generation never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_vld_r <= '0;
      live_r    <= '0;
    end else begin
      if (req.gen_we) begin
        gen_vld_r[req.gen_id] <= 1'b1;
      end
      if (req.live_set) begin
        live_r[req.live_id] <= 1'b1;
      end else if (req.live_clr) begin
        live_r[req.live_id] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.gen_we) begin
      gen_mem[req.gen_id] <= req.gen_wdata;
    end
    if (req.slot_we) begin
      slot_mem[req.slot_wid] <= req.slot_wdata;
    end
    if (req.rd) begin
      gen_rd_r     <= gen_mem[req.rd_id];
      gen_vld_rd_r <= gen_vld_r[req.rd_id];
      live_rd_r    <= live_r[req.rd_id];
      slot_rd_r    <= slot_mem[req.rd_id];
    end
  end

  assign gen_q  = gen_vld_rd_r ? gen_rd_r : '0;
  assign live_q = live_rd_r;
  assign slot_q = slot_rd_r;

endmodule

// ===== src/gsp_dense_store.sv =====
module gsp_dense_store
  import gsp_pkg::*;
(
  input  logic    clk,
  input  ds_req_t req,
  output word_t   rx,
  output word_t   ry,
  output id_t     rowner
);

  word_t x_mem     [POOL_SIZE];
  word_t y_mem     [POOL_SIZE];
  id_t   owner_mem [POOL_SIZE];
  word_t rx_r;
  word_t ry_r;
  id_t   rowner_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      x_mem[req.wr_slot]     <= req.wx;
      y_mem[req.wr_slot]     <= req.wy;
      owner_mem[req.wr_slot] <= req.wowner;
    end
    if (req.rd) begin
      rx_r     <= x_mem[req.rd_slot];
      ry_r     <= y_mem[req.rd_slot];
      rowner_r <= owner_mem[req.rd_slot];
    end
  end

  assign rx     = rx_r;
  assign ry     = ry_r;
  assign rowner = rowner_r;

endmodule

// ===== src/generational_slot_pool.sv =====
// Generational slot pool: hands out handles (id plus generation) and keeps the
// two-word payloads densely packed.
// Input channel: in_op selects allocate or release. Allocate takes in_x_bits
// and in_y_bits; release takes in_handle_id and in_handle_gen. An item is
// accepted when in_valid is high and in_stall is low.
// Result channel: one result item per input item, held in an output register
// until out_valid is high with out_stall low.
// Each item passes through the accept cycle, a step for the first dependent
// memory read (free stack pop, or handle table lookup), and a step for the
// second (generation, or the last dense entry). The next item is taken in the
// cycle after the final step, never while an item is still in flight.
// An item is held in its final cycle while an earlier result still waits in a
// stalled output register. One item is in flight at a time, so every write
// lands before the next item reads the memories.
// Reset clears the counters and per-id flags at once; no clearing pass is
// needed and the block accepts an item in the first cycle after reset.
module generational_slot_pool
  import gsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [63:0] in_x_bits,
  input  logic [63:0] in_y_bits,
  input  logic [7:0]  in_handle_id,
  input  logic [15:0] in_handle_gen,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_id,
  output logic [15:0] out_gen,
  output logic [7:0]  out_dense_slot,
  output logic        out_moved,
  output logic [8:0]  out_live_count
);

  state_t  state_r, state_nxt;
  cnt_t    live_cnt_r;
  cnt_t    free_top;
  cnt_t    top;
  logic    full_r;
  logic    stale_r;
  logic    stale;
  logic    moved;
  logic    accept;
  logic    out_free;
  logic    emit;
  word_t   x_r, y_r;
  id_t     hid_r;
  gen_t    hgen_r;
  id_t     id_r;
  id_t     slot_r;
  id_t     top_r;
  gen_t    gen_r;

  logic    out_valid_r;
  status_t status_r, status_nxt;
  id_t     out_id_r, out_id_nxt;
  gen_t    out_gen_r, out_gen_nxt;
  id_t     dslot_r, dslot_nxt;
  logic    moved_r, moved_nxt;
  cnt_t    live_out_r;

  fs_req_t fs_req;
  ht_req_t ht_req;
  ds_req_t ds_req;
  id_t     pop_id;
  gen_t    gen_q;
  logic    live_q;
  id_t     slot_q;
  word_t   rx, ry;
  id_t     rowner;

  gsp_free_stack u_free (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (fs_req),
    .free_top (free_top),
    .pop_id   (pop_id)
  );

  gsp_handle_tab u_htab (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ht_req),
    .gen_q  (gen_q),
    .live_q (live_q),
    .slot_q (slot_q)
  );

  gsp_dense_store u_dense (
    .clk    (clk),
    .req    (ds_req),
    .rx     (rx),
    .ry     (ry),
    .rowner (rowner)
  );

  assign free_top = CNT_W'(POOL_SIZE) - live_cnt_r;
  assign top      = live_cnt_r - 1'b1;
  assign out_free = !out_valid_r || !out_stall;
  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign stale    = !live_q || (gen_q != hgen_r) || (live_cnt_r == '0);
  assign moved    = !stale_r && (slot_r != top_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (op_t'(in_op) == OP_ALLOC) ? S_A1 : S_R1;
        end
      end
      S_A1: state_nxt = S_A2;
      S_A2: if (out_free) state_nxt = S_IDLE;
      S_R1: state_nxt = S_R2;
      S_R2: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory requests and result formation.
  always_comb begin
    fs_req      = '0;
    ht_req      = '0;
    ds_req      = '0;
    emit        = 1'b0;
    status_nxt  = ST_OK;
    out_id_nxt  = '0;
    out_gen_nxt = '0;
    dslot_nxt   = '0;
    moved_nxt   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (op_t'(in_op) == OP_ALLOC) begin
            fs_req.pop = (live_cnt_r != CNT_W'(POOL_SIZE));
          end else begin
            ht_req.rd    = 1'b1;
            ht_req.rd_id = in_handle_id;
          end
        end
      end
      S_A1: begin
        if (!full_r) begin
          ht_req.rd         = 1'b1;
          ht_req.rd_id      = pop_id;
          ht_req.live_set   = 1'b1;
          ht_req.live_id    = pop_id;
          ht_req.slot_we    = 1'b1;
          ht_req.slot_wid   = pop_id;
          ht_req.slot_wdata = live_cnt_r[ID_W-1:0];
          ds_req.we         = 1'b1;
          ds_req.wr_slot    = live_cnt_r[ID_W-1:0];
          ds_req.wx         = x_r;
          ds_req.wy         = y_r;
          ds_req.wowner     = pop_id;
        end
      end
      S_A2: begin
        emit = out_free;
        if (full_r) begin
          status_nxt = ST_FULL;
        end else begin
          out_id_nxt  = id_r;
          out_gen_nxt = gen_q;
          dslot_nxt   = slot_r;
        end
      end
      S_R1: begin
        if (!stale) begin
          ds_req.rd        = 1'b1;
          ds_req.rd_slot   = top[ID_W-1:0];
          ht_req.gen_we    = 1'b1;
          ht_req.gen_id    = hid_r;
          ht_req.gen_wdata = gen_q + 1'b1;
          ht_req.live_clr  = 1'b1;
          ht_req.live_id   = hid_r;
          fs_req.push      = 1'b1;
          fs_req.push_id   = hid_r;
        end
      end
      S_R2: begin
        emit       = out_free;
        out_id_nxt = hid_r;
        if (stale_r) begin
          status_nxt = ST_STALE;
        end else begin
          out_gen_nxt = gen_r;
          dslot_nxt   = slot_r;
          moved_nxt   = moved;
          // The last dense entry refills the freed slot.
          if (moved && out_free) begin
            ds_req.we         = 1'b1;
            ds_req.wr_slot    = slot_r;
            ds_req.wx         = rx;
            ds_req.wy         = ry;
            ds_req.wowner     = rowner;
            ht_req.slot_we    = 1'b1;
            ht_req.slot_wid   = rowner;
            ht_req.slot_wdata = slot_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_A1 && !full_r) begin
        live_cnt_r <= live_cnt_r + 1'b1;
      end else if (state_r == S_R1 && !stale) begin
        live_cnt_r <= top;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_x_bits;
      y_r    <= in_y_bits;
      hid_r  <= in_handle_id;
      hgen_r <= in_handle_gen;
      full_r <= (live_cnt_r == CNT_W'(POOL_SIZE));
    end
    if (state_r == S_A1) begin
      id_r   <= pop_id;
      slot_r <= live_cnt_r[ID_W-1:0];
    end
    if (state_r == S_R1) begin
      stale_r <= stale;
      slot_r  <= slot_q;
      top_r   <= top[ID_W-1:0];
      gen_r   <= gen_q + 1'b1;
    end
    if (emit) begin
      status_r   <= status_nxt;
      out_id_r   <= out_id_nxt;
      out_gen_r  <= out_gen_nxt;
      dslot_r    <= dslot_nxt;
      moved_r    <= moved_nxt;
      live_out_r <= live_cnt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_id         = out_id_r;
  assign out_gen        = out_gen_r;
  assign out_dense_slot = dslot_r;
  assign out_moved      = moved_r;
  assign out_live_count = live_out_r;

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_cnt_r <= CNT_W'(POOL_SIZE))
    else $error("live count above pool size");

  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_A1 && state_r != S_R1) |=> $stable(live_cnt_r))
    else $error("live count changed outside an update cycle");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A1 && full_r) |=> $stable(live_cnt_r))
    else $error("allocate on a full pool changed the live count");

  a_move_below_top: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_R2 && moved) |-> (slot_r < top_r))
    else $error("freed slot lies above the last dense slot");

endmodule

// ===== dv/generational_slot_pool_checker.sv =====
module slot_pool_checker
  import gsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_handle_id,
  input  logic [15:0] in_handle_gen,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_id,
  input  logic [15:0] out_gen,
  input  logic [7:0]  out_dense_slot,
  input  logic        out_moved,
  input  logic [8:0]  out_live_count,
  output int          failures,
  output int          awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_CAP = 100;

  typedef struct packed {
    status_t status;
    id_t     id;
    gen_t    gen;
    id_t     slot;
    logic    moved;
    cnt_t    live;
  } pool_result_t;

  // Mirror of the pool: free id stack, counters, and per-id and per-slot tables.
  id_t  spare_ids[POOL_SIZE];
  cnt_t free_cnt;
  cnt_t live_cnt;
  gen_t gens[POOL_SIZE];
  bit   live_flag[POOL_SIZE];
  id_t  slot_for_id[POOL_SIZE];
  id_t  id_in_slot[POOL_SIZE];

  pool_result_t awaited_results[$];
  int           fail_count = 0;

  assign failures = fail_count;

  function automatic void clear_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      spare_ids[i]   = id_t'(i);
      gens[i]        = '0;
      live_flag[i]   = 1'b0;
      slot_for_id[i] = '0;
      id_in_slot[i]  = '0;
    end
    free_cnt = cnt_t'(POOL_SIZE);
    live_cnt = '0;
  endfunction

  function automatic pool_result_t apply_handle_op(op_t op, id_t hid, gen_t hgen);
    pool_result_t r;
    id_t          freed, last, occ;
    r = '{status: ST_OK, id: '0, gen: '0, slot: '0, moved: 1'b0, live: '0};
    if (op == OP_ALLOC) begin
      if (free_cnt == 0 || live_cnt >= POOL_SIZE) begin
        r.status = ST_FULL;
      end else begin
        free_cnt--;
        r.id = spare_ids[free_cnt];
        r.slot = live_cnt[ID_W-1:0];
        live_cnt++;
        id_in_slot[r.slot] = r.id;
        slot_for_id[r.id] = r.slot;
        live_flag[r.id] = 1'b1;
        r.gen = gens[r.id];
      end
    end else if (!live_flag[hid] || gens[hid] != hgen || live_cnt == 0) begin
      r.status = ST_STALE;
      r.id = hid;
    end else begin
      freed = slot_for_id[hid];
      live_cnt--;
      last = live_cnt[ID_W-1:0];
      // The last dense entry fills the hole unless the hole is the last entry.
      if (freed != last) begin
        occ = id_in_slot[last];
        id_in_slot[freed] = occ;
        slot_for_id[occ] = freed;
        r.moved = 1'b1;
      end
      live_flag[hid] = 1'b0;
      gens[hid] = gens[hid] + 1'b1;
      if (free_cnt < POOL_SIZE) begin
        spare_ids[free_cnt] = hid;
        free_cnt++;
      end
      r.id = hid;
      r.gen = gens[hid];
      r.slot = freed;
    end
    r.live = live_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    pool_result_t want, got;
    if (!rst_n) begin
      clear_pool();
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{status: status_t'(out_status), id: out_id, gen: out_gen,
                slot: out_dense_slot, moved: out_moved, live: out_live_count};
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $display("%0t: result item with none expected: status %0d id %0d gen %0d",
                     $time, got.status, got.id, got.gen);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
              $display({"%0t: mismatch: expected status %0d id %0d gen %0d slot %0d",
                        " moved %0d live %0d, got status %0d id %0d gen %0d slot %0d",
                        " moved %0d live %0d"},
                       $time, want.status, want.id, want.gen, want.slot, want.moved,
                       want.live, got.status, got.id, got.gen, got.slot, got.moved,
                       got.live);
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(apply_handle_op(op_t'(in_op), in_handle_id,
                                                  in_handle_gen));
    end
    awaiting <= awaited_results.size();
  end

endmodule

// ===== dv/generational_slot_pool_tb.sv =====
module generational_slot_pool_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsp_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 700;
  localparam int WRAP_PAIRS   = 16;
  localparam int RETIRED_MAX  = 64;
  localparam int NOISE_PCT    = 10;

  typedef struct packed {
    id_t  id;
    gen_t gen;
  } handle_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic        in_op          = 1'b0;
  logic [63:0] in_x_bits      = '0;
  logic [63:0] in_y_bits      = '0;
  logic [7:0]  in_handle_id   = '0;
  logic [15:0] in_handle_gen  = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_id;
  logic [15:0] out_gen;
  logic [7:0]  out_dense_slot;
  logic        out_moved;
  logic [8:0]  out_live_count;

  int result_failures;
  int results_pending;

  bit      rx_steady = 1'b0;
  int      rx_mode   = 0;
  int      rx_left   = 0;
  bit      gaps_on   = 1'b1;
  int      burst_left = 0;
  int      random_items = 0;
  int      idle_cycles = 0;
  op_t     issued_ops[$];
  handle_t live_handles[$];
  handle_t retired_handles[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  generational_slot_pool dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_x_bits      (in_x_bits),
    .in_y_bits      (in_y_bits),
    .in_handle_id   (in_handle_id),
    .in_handle_gen  (in_handle_gen),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_id         (out_id),
    .out_gen        (out_gen),
    .out_dense_slot (out_dense_slot),
    .out_moved      (out_moved),
    .out_live_count (out_live_count)
  );

  slot_pool_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_handle_id   (in_handle_id),
    .in_handle_gen  (in_handle_gen),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_id         (out_id),
    .out_gen        (out_gen),
    .out_dense_slot (out_dense_slot),
    .out_moved      (out_moved),
    .out_live_count (out_live_count),
    .failures       (result_failures),
    .awaiting       (results_pending)
  );

  // Receiver: stretches of no stalls, light stalls and heavy stalls.
  always @(posedge clk) begin
    if (!rst_n || rx_steady) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Handles are learnt from allocate results. Sampling at the falling edge sees the
  // item that the next rising edge accepts, away from the stimulus process.
  always @(negedge clk) begin
    op_t done_op;
    if (rst_n && out_valid && !out_stall && issued_ops.size() != 0) begin
      done_op = issued_ops.pop_front();
      if (done_op == OP_ALLOC && status_t'(out_status) == ST_OK)
        live_handles.push_back('{id: out_id, gen: out_gen});
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("generational_slot_pool_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic word_t random_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic handle_t take_handle(int idx);
    handle_t h;
    h = live_handles[idx];
    live_handles.delete(idx);
    return h;
  endfunction

  task automatic send_item(op_t op, word_t x, word_t y, id_t hid, gen_t hgen);
    int gap;
    in_valid      <= 1'b1;
    in_op         <= op;
    in_x_bits     <= x;
    in_y_bits     <= y;
    in_handle_id  <= hid;
    in_handle_gen <= hgen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    issued_ops.push_back(op);
    if (burst_left > 0) begin
      burst_left--;
    end else if (gaps_on) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic idle_one();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    idle_one();
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic send_alloc();
    send_item(OP_ALLOC, random_word(), random_word(), id_t'($urandom), gen_t'($urandom));
  endtask

  task automatic release_handle(handle_t h);
    retired_handles.push_back(h);
    if (retired_handles.size() > RETIRED_MAX) void'(retired_handles.pop_front());
    send_item(OP_RELEASE, random_word(), random_word(), h.id, h.gen);
  endtask

  // Releases that must be refused: random handles, old handles, or live ids with
  // a wrong generation.
  task automatic send_bad_release();
    handle_t h;
    int      kind;
    kind = $urandom_range(0, 2);
    h = '{id: id_t'($urandom), gen: gen_t'($urandom)};
    if (kind == 1 && retired_handles.size() != 0) begin
      h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
    end else if (kind == 2 && live_handles.size() != 0) begin
      h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      h.gen = h.gen ^ gen_t'($urandom_range(1, 65535));
    end
    send_item(OP_RELEASE, random_word(), random_word(), h.id, h.gen);
  endtask

  task automatic run_phase(int alloc_pct, int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < NOISE_PCT)
        send_bad_release();
      else if (live_handles.size() == 0 || $urandom_range(0, 99) < alloc_pct)
        send_alloc();
      else
        release_handle(take_handle($urandom_range(0, live_handles.size() - 1)));
      random_items++;
    end
  endtask

  initial begin
    handle_t h;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Releases into an empty pool, then a few allocations with extreme payloads.
    send_item(OP_RELEASE, '0, '1, 8'hFF, 16'hFFFF);
    send_item(OP_RELEASE, '1, '0, 8'h00, 16'h0000);
    send_item(OP_ALLOC, '0, '0, '0, '0);
    send_item(OP_ALLOC, '1, '1, '1, '1);
    send_item(OP_ALLOC, {32{2'b10}}, {32{2'b01}}, 8'h55, 16'hAAAA);
    send_alloc();
    wait_for_results();
    // The newest entry sits in the last dense slot, so nothing moves.
    release_handle(take_handle(3));
    h = take_handle(0);
    send_item(OP_RELEASE, random_word(), random_word(), h.id, ~h.gen);
    release_handle(h);
    release_handle(h);
    send_alloc();
    wait_for_results();

    // Fill past full, drain past empty, then mixed traffic.
    run_phase(100, 320);
    wait_for_results();
    run_phase(0, 320);
    wait_for_results();
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       run_phase(30, $urandom_range(40, 120));
        1:       run_phase(50, $urandom_range(40, 120));
        default: run_phase(70, $urandom_range(40, 120));
      endcase
      wait_for_results();
    end

    do begin
      while (live_handles.size() != 0) release_handle(take_handle(0));
      wait_for_results();
    end while (live_handles.size() != 0);

    // With the pool empty the same id comes back each time, so its generation
    // climbs by one on every release.
    gaps_on = 1'b0;
    rx_steady <= 1'b1;
    for (int k = 0; k < WRAP_PAIRS; k++) begin
      send_alloc();
      idle_one();
      while (live_handles.size() == 0) @(posedge clk);
      release_handle(take_handle(0));
    end
    wait_for_results();
    rx_steady <= 1'b0;

    repeat (16) @(posedge clk);
    if (result_failures == 0)
      $display("generational_slot_pool_tb: PASS");
    else
      $display("generational_slot_pool_tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
src/gsp_pkg.sv
src/gsp_free_stack.sv
src/gsp_handle_tab.sv
src/gsp_dense_store.sv
src/generational_slot_pool.sv
dv/generational_slot_pool_checker.sv
dv/generational_slot_pool_tb.sv
